// File: rtl/tare_pkg.sv
// Package for the trend-adaptive RTT estimator: constants, types and the
// controller/datapath command and status structures. No dependencies.
package tare_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int RING_DEPTH = MAX_WINDOW + 1;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int WIN_W      = 7;
    localparam int GAIN_W     = 17;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ALPHA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BETA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_WINDOW = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PUSH, ST_RD, ST_DIV, ST_ACC, ST_MEAN, ST_GAIN,
        ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_FIN, ST_DONE, ST_OUT
    } tare_state_t;

    typedef struct packed {
        logic load;
        logic push;
        logic first;
        logic rd;
        logic div_start;
        logic acc;
        logic mean_start;
        logic gain;
        logic mul1;
        logic mul2;
        logic mul3;
        logic mul4;
        logic finish;
    } tare_cmd_t;

    typedef struct packed {
        logic first;
        logic pairs_left;
        logic div_done;
    } tare_status_t;

endpackage

// File: rtl/tare_divider.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by
// 32-bit divisor. Uses tare_pkg.
module tare_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import tare_pkg::*;

    logic [63:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[31:0], quot_reg[63]};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == 7'd1);
    assign quotient = quot_next;
endmodule

// File: rtl/tare_datapath.sv
// Datapath: configuration registers, sample ring memory, trend accumulation,
// gain and EWMA arithmetic. Uses tare_pkg and tare_divider.
module tare_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tare_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tare_pkg::GAIN_W-1:0]   cfg_data,
    input  logic [31:0]                   sample_in,
    input  tare_pkg::tare_cmd_t           cmd,
    output tare_pkg::tare_status_t        status,
    output logic [31:0]                   srtt_out,
    output logic [31:0]                   rttvar_out,
    output logic [16:0]                   trend_out
);
    import tare_pkg::*;

    logic [GAIN_W-1:0] alpha_cfg_reg, beta_cfg_reg;
    logic [WIN_W-1:0]  win_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_cfg_reg <= 17'd8192;
            beta_cfg_reg  <= 17'd16384;
            win_cfg_reg   <= 7'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_ALPHA:   alpha_cfg_reg <= cfg_data;
                REG_BASE_BETA:    beta_cfg_reg  <= cfg_data;
                REG_TREND_WINDOW: win_cfg_reg   <= cfg_data[WIN_W-1:0];
                default:          ;
            endcase
        end
    end

    logic [31:0] ring [RING_DEPTH];
    logic [RING_AW-1:0] head_reg, rd_ptr_reg;
    logic [WIN_W:0]   fill_reg, pairs_reg;
    logic [31:0] sample_reg, cur_reg, rd_data_reg;
    logic        first_reg;
    logic [31:0] srtt_reg, rttvar_reg;
    logic [63:0] sum_reg;
    logic [16:0] trend_reg;
    logic [17:0] alpha_reg;
    logic [16:0] beta_reg;
    logic [WIN_W:0] win_eff;
    logic [GAIN_W-1:0] ba, bb;

    always_comb
    begin
        win_eff = {1'b0, win_cfg_reg};
        if (win_cfg_reg == '0)
        begin
            win_eff = 8'd1;
        end
        else if (win_cfg_reg > 7'(MAX_WINDOW))
        begin
            win_eff = 8'(MAX_WINDOW);
        end
        ba = alpha_cfg_reg > ONE_Q16 ? ONE_Q16 : alpha_cfg_reg;
        bb = beta_cfg_reg > ONE_Q16 ? ONE_Q16 : beta_cfg_reg;
    end

    logic [RING_AW-1:0] head_inc, head_dec, ptr_dec;
    assign head_inc = (head_reg == RING_AW'(RING_DEPTH-1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? RING_AW'(RING_DEPTH-1) : head_reg - 1'b1;
    assign ptr_dec  = (rd_ptr_reg == '0) ? RING_AW'(RING_DEPTH-1) : rd_ptr_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring[head_reg] <= sample_reg;
        end
        rd_data_reg <= ring[rd_ptr_reg];
    end

    logic        div_start, div_done;
    logic [63:0] div_num, div_q;
    logic [31:0] div_den;
    logic [31:0] diff;
    logic        mean_mode_reg;

    assign diff = cur_reg > rd_data_reg ? cur_reg - rd_data_reg : rd_data_reg - cur_reg;
    assign div_start = cmd.div_start || cmd.mean_start;
    assign div_num = cmd.mean_start ? sum_reg : {16'd0, diff, 16'd0};
    assign div_den = cmd.mean_start ? {24'd0, pairs_reg} : rd_data_reg;

    tare_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor(div_den), .done(div_done), .quotient(div_q)
    );

    logic        prev_zero_reg;
    logic [WIN_W:0] fill_new;
    logic [WIN_W:0] cnt_reg;

    assign fill_new = (fill_reg + 1'b1 > win_eff + 1'b1) ? win_eff + 1'b1 : fill_reg + 1'b1;

    // Multiplication stage registers
    logic signed [33:0] d_reg;
    logic [31:0] absd_reg;
    logic [17:0] ag_reg;
    logic signed [52:0] ad_reg;
    logic [49:0] dev_reg;
    logic [48:0] vp1_reg;
    logic [66:0] bd_reg;
    logic [33:0] one_m_beta;

    assign one_m_beta = 34'(ONE_Q16) - 34'(beta_reg);

    logic signed [65:0] s16;
    logic [66:0] var16;
    assign s16   = $signed({2'b0, srtt_reg, 16'd0}) + 66'(ad_reg);
    assign var16 = 67'(vp1_reg) + 67'(bd_reg[66:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            fill_reg   <= '0;
            first_reg  <= 1'b1;
            srtt_reg   <= '0;
            rttvar_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                head_reg <= head_inc;
                fill_reg <= fill_new;
            end
            if (cmd.first)
            begin
                srtt_reg   <= sample_reg;
                rttvar_reg <= {1'b0, sample_reg[31:1]};
                first_reg  <= 1'b0;
            end
            if (cmd.finish)
            begin
                if (s16 < 0)
                    srtt_reg <= '0;
                else if (s16[65:48] != '0)
                    srtt_reg <= '1;
                else
                    srtt_reg <= s16[47:16];
                rttvar_reg <= (var16[66:48] != '0) ? '1 : var16[47:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_in;
            trend_reg  <= '0;
        end
        if (cmd.push)
        begin
            pairs_reg  <= fill_new - 1'b1;
            cnt_reg    <= fill_new - 1'b1;
            rd_ptr_reg <= head_dec;
            cur_reg    <= sample_reg;
            sum_reg    <= '0;
        end
        if (cmd.rd)
        begin
            rd_ptr_reg <= ptr_dec;
        end
        if (cmd.div_start)
        begin
            prev_zero_reg <= (rd_data_reg == '0);
            mean_mode_reg <= 1'b0;
        end
        if (cmd.mean_start)
        begin
            mean_mode_reg <= 1'b1;
        end
        if (cmd.acc)
        begin
            if (!prev_zero_reg)
                sum_reg <= sum_reg + div_q;
            cur_reg <= rd_data_reg;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.gain && mean_mode_reg)
        begin
            trend_reg <= (div_q > 64'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];
        end
        if (cmd.mul1)
        begin
            alpha_reg <= 18'((35'(ba) * (35'(ONE_Q16) + 35'(trend_reg))) >> 16);
            beta_reg  <= 17'((34'(bb) * (34'(ONE_Q16) - 34'(trend_reg))) >> 16);
            d_reg     <= $signed({2'b0, sample_reg}) - $signed({2'b0, srtt_reg});
        end
        if (cmd.mul2)
        begin
            absd_reg <= d_reg[33] ? 32'(-d_reg) : d_reg[31:0];
            ag_reg   <= alpha_reg > 18'(ONE_Q16) ? alpha_reg - 18'(ONE_Q16)
                                                 : 18'(ONE_Q16) - alpha_reg;
            ad_reg   <= 53'($signed({1'b0, alpha_reg}) * d_reg);
            vp1_reg  <= 49'(one_m_beta * 34'(rttvar_reg));
        end
        if (cmd.mul3)
        begin
            dev_reg <= 50'(absd_reg) * 50'(ag_reg);
        end
        if (cmd.mul4)
        begin
            bd_reg <= 67'(beta_reg) * 67'(dev_reg);
        end
    end

    assign status.first      = first_reg;
    assign status.pairs_left = (cnt_reg != '0);
    assign status.div_done   = div_done;
    assign srtt_out   = srtt_reg;
    assign rttvar_out = rttvar_reg;
    assign trend_out  = trend_reg;
endmodule

// File: rtl/tare_controller.sv
// Controller state machine sequencing one sample through the datapath and
// holding the output handshake. Uses tare_pkg.
module tare_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  tare_pkg::tare_status_t status,
    output tare_pkg::tare_cmd_t    cmd
);
    import tare_pkg::*;

    tare_state_t state_reg, state_next;
    logic        mean_reg, mean_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mean_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mean_reg  <= mean_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mean_next  = mean_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_PUSH;
            ST_PUSH: state_next = status.first ? ST_OUT : ST_RD;
            ST_RD:
            begin
                mean_next  = 1'b0;
                state_next = status.pairs_left ? ST_ACC : ST_MEAN;
            end
            ST_ACC:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = mean_reg ? ST_GAIN : ST_DONE;
            end
            ST_DONE: state_next = status.pairs_left ? ST_ACC : ST_MEAN;
            ST_MEAN:
            begin
                mean_next  = 1'b1;
                state_next = ST_DIV;
            end
            ST_GAIN: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_MUL4;
            ST_MUL4: state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PUSH:
            begin
                cmd.push  = 1'b1;
                cmd.first = status.first;
            end
            ST_ACC:  cmd.div_start = 1'b1;
            ST_DIV:
            begin
                cmd.acc = status.div_done && !mean_reg;
                cmd.rd  = status.div_done && !mean_reg;
            end
            ST_MEAN: cmd.mean_start = 1'b1;
            ST_GAIN: cmd.gain = 1'b1;
            ST_MUL1: cmd.mul1 = 1'b1;
            ST_MUL2: cmd.mul2 = 1'b1;
            ST_MUL3: cmd.mul3 = 1'b1;
            ST_MUL4:
            begin
                cmd.mul4 = 1'b1;
            end
            ST_FIN:  cmd.finish = 1'b1;
            ST_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// File: rtl/trend_adaptive_rtt_estimator.sv
// Top level of the trend-adaptive RTT estimator: controller and datapath.
// Uses tare_pkg, tare_controller and tare_datapath.
//
//   channel   direction  payload
//   s_axis    in         rtt_sample_us
//   m_axis    out        smoothed_rtt_us, rtt_variation_us, trend_q16
//   cfg       in         base_alpha, base_beta, trend_window
//
// One transaction at a time. A later sample passes through acceptance, one serial
// division per held pair, one more for the mean, and then the gain and EWMA steps,
// so its time grows with the number of pairs held. A first sample sets srtt to the
// sample and rttvar to half of it. No clearing pass follows reset.
// A result waits in registers until taken; no new sample enters meanwhile.
module trend_adaptive_rtt_estimator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,   // rtt_sample_us
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // smoothed_rtt_us [31:0], rtt_variation_us [63:32], trend_q16 [80:64], zeros
    output logic [87:0]                     m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [tare_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tare_pkg::GAIN_W-1:0]     cfg_data
);
    import tare_pkg::*;

    tare_cmd_t    cmd;
    tare_status_t status;
    logic [31:0]  srtt, rttvar;
    logic [16:0]  trend;

    tare_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .status(status), .cmd(cmd)
    );

    tare_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .sample_in(s_axis_tdata), .cmd(cmd), .status(status),
        .srtt_out(srtt), .rttvar_out(rttvar), .trend_out(trend)
    );

    assign m_axis_tdata = {7'd0, trend, rttvar, srtt};
endmodule

// File: tb/trend_adaptive_rtt_estimator_test.sv
// Self-checking testbench for trend_adaptive_rtt_estimator: a directed table, then random
// samples and settings, each result checked against a known table value or a cycle-free
// estimator model. Depends on tare_pkg and the RTL of the block.
module trend_adaptive_rtt_estimator_test;
    import tare_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_ITEMS   = 250;
    localparam int LONG_HOLD      = 6000;
    localparam int EXP_DEPTH      = 512;
    localparam int ROW_DEPTH      = 64;

    typedef struct packed {
        logic [31:0] srtt;
        logic [31:0] rttvar;
        logic [16:0] trend;
    } estimate_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          value;
        bit                   typed;
        estimate_t            known;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [87:0]          m_axis_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;

    logic [31:0] sample_hist [RING_DEPTH];
    int unsigned hist_head;
    int unsigned hist_fill;
    logic [31:0] est_srtt;
    logic [31:0] est_rttvar;
    bit          est_first;
    logic [16:0] gain_alpha;
    logic [16:0] gain_beta;
    logic [6:0]  pair_window;

    estimate_t   expected_mem [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    stim_row_t   directed_rows [ROW_DEPTH];
    int          row_count;
    int          mismatch_count;
    int          results_taken;
    int          idle_cycles;
    bit          stimulus_done;

    trend_adaptive_rtt_estimator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned hist_back(int unsigned back);
        return (hist_head + RING_DEPTH + RING_DEPTH - 1 - back) % RING_DEPTH;
    endfunction

    function automatic estimate_t estimate_rtt(logic [31:0] s);
        int unsigned w;
        longint unsigned ba, bb, trend, sum, alpha, beta, absd, ag, dev16, var16;
        longint unsigned diff;
        longint signed d, s16;
        int unsigned pairs;
        logic [31:0] cur, prev;
        estimate_t r;
        w = pair_window;
        if (w < 1)
            w = 1;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        ba = (gain_alpha > ONE_Q16) ? 65536 : gain_alpha;
        bb = (gain_beta > ONE_Q16) ? 65536 : gain_beta;
        trend = 0;
        sample_hist[hist_head] = s;
        hist_head = (hist_head + 1) % RING_DEPTH;
        hist_fill = hist_fill + 1;
        if (hist_fill > w + 1)
            hist_fill = w + 1;
        if (est_first)
        begin
            est_srtt = s;
            est_rttvar = s >> 1;
            est_first = 1'b0;
        end
        else
        begin
            pairs = (hist_fill > 0) ? hist_fill - 1 : 0;
            sum = 0;
            for (int unsigned i = 0; i < pairs; i++)
            begin
                cur = sample_hist[hist_back(i)];
                prev = sample_hist[hist_back(i + 1)];
                if (prev != 0)
                begin
                    diff = (cur > prev) ? cur - prev : prev - cur;
                    sum += (diff << 16) / prev;
                end
            end
            if (pairs > 0)
                trend = sum / pairs;
            if (trend > 65536)
                trend = 65536;
            alpha = (ba * (65536 + trend)) >> 16;
            beta = (bb * (65536 - trend)) >> 16;
            d = longint'(s) - longint'(est_srtt);
            s16 = (longint'(est_srtt) <<< 16) + longint'(alpha) * d;
            absd = (d < 0) ? -d : d;
            ag = (alpha > 65536) ? alpha - 65536 : 65536 - alpha;
            dev16 = absd * ag;
            var16 = (65536 - beta) * longint'(est_rttvar) + ((beta * dev16) >> 16);
            if (s16 < 0)
                est_srtt = 32'd0;
            else if ((s16 >>> 16) > 64'hFFFF_FFFF)
                est_srtt = 32'hFFFF_FFFF;
            else
                est_srtt = s16[47:16];
            var16 = var16 >> 16;
            est_rttvar = (var16 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : var16[31:0];
        end
        r.srtt = est_srtt;
        r.rttvar = est_rttvar;
        r.trend = trend[16:0];
        return r;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        stim_row_t r;
        r = '{1'b1, idx, v, 1'b0, '0};
        directed_rows[row_count] = r;
        row_count++;
    endfunction

    function automatic void add_sample(logic [31:0] v);
        stim_row_t r;
        r = '{1'b0, '0, v, 1'b0, '0};
        directed_rows[row_count] = r;
        row_count++;
    endfunction

    function automatic void add_known(logic [31:0] v, estimate_t e);
        stim_row_t r;
        r = '{1'b0, '0, v, 1'b1, e};
        directed_rows[row_count] = r;
        row_count++;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[GAIN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BASE_ALPHA:   gain_alpha = v[16:0];
            REG_BASE_BETA:    gain_beta = v[16:0];
            REG_TREND_WINDOW: pair_window = v[6:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(logic [31:0] v, bit typed, estimate_t known);
        int gap;
        estimate_t e;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do
            @(posedge clk);
        while (!s_axis_tready);
        e = estimate_rtt(v);
        expected_mem[exp_wr % EXP_DEPTH] = typed ? known : e;
        exp_wr++;
    endtask

    function automatic logic [31:0] pick_sample(logic [31:0] last);
        int mode;
        longint unsigned span, lo, hi;
        mode = $urandom_range(0, 99);
        if (mode < 45)
        begin
            span = (longint'(last) >> $urandom_range(1, 6)) + 1;
            lo = (last > span) ? last - span : 0;
            hi = (longint'(last) + span > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : last + span;
            return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
        end
        else if (mode < 75)
            return $urandom;
        else if (mode < 83)
            return 32'd0;
        else if (mode < 90)
            return 32'hFFFF_FFFF;
        else
            return $urandom_range(0, 16);
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd65536;
            2: return 32'd131071;
            3: return 32'd8192;
            default: return $urandom_range(0, 131071);
        endcase
    endfunction

    initial
    begin
        estimate_t none;
        logic [31:0] last;
        logic [31:0] win;
        int sent, phase_len;
        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stimulus_done = 1'b0;
        hist_head = 0;
        hist_fill = 0;
        est_srtt = '0;
        est_rttvar = '0;
        est_first = 1'b1;
        gain_alpha = 17'd8192;
        gain_beta = 17'd16384;
        pair_window = 7'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_known(32'd0, '{32'd0, 32'd0, 17'd0});
        add_sample(32'hFFFF_FFFF);
        add_sample(32'd1);
        add_sample(32'hFFFF_FFFF);
        add_cfg(REG_BASE_ALPHA, 32'd65536);
        add_cfg(REG_BASE_BETA, 32'd0);
        add_cfg(REG_TREND_WINDOW, 32'd2);
        add_sample(32'd1000);
        add_sample(32'd3000);
        add_sample(32'd0);
        add_sample(32'hFFFF_FFFF);
        add_cfg(REG_BASE_ALPHA, 32'd131071);
        add_cfg(REG_BASE_BETA, 32'd131071);
        add_cfg(REG_TREND_WINDOW, 32'd0);
        add_sample(32'd5000);
        add_sample(32'd5100);
        add_sample(32'd4000);
        add_cfg(REG_TREND_WINDOW, 32'd127);
        add_cfg(REG_UNUSED, 32'd131071);
        add_sample(32'h8000_0000);
        add_sample(32'h7FFF_FFFF);
        add_sample(32'd123456);
        add_cfg(REG_TREND_WINDOW, 32'd1);
        add_cfg(REG_BASE_ALPHA, 32'd0);
        add_cfg(REG_BASE_BETA, 32'd65536);
        add_sample(32'd200);
        add_sample(32'd250);
        add_cfg(REG_TREND_WINDOW, 32'd8);
        add_sample(32'd300);
        add_sample(32'd0);
        add_sample(32'd310);
        add_cfg(REG_BASE_ALPHA, 32'd8192);
        add_cfg(REG_BASE_BETA, 32'd16384);
        add_sample(32'd320);

        for (int i = 0; i < row_count; i++)
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            else
                send_sample(directed_rows[i].value, directed_rows[i].typed,
                            directed_rows[i].known);
        end

        last = 32'd320;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_reg(REG_BASE_ALPHA, pick_gain());
            write_reg(REG_BASE_BETA, pick_gain());
            case ($urandom_range(0, 9))
                0: win = 32'd0;
                1: win = 32'd64;
                2: win = 32'd127;
                3: win = $urandom_range(0, 127);
                default: win = $urandom_range(1, 8);
            endcase
            write_reg(REG_TREND_WINDOW, win);
            phase_len = (win > 16) ? 8 : $urandom_range(15, 30);
            repeat (phase_len)
            begin
                last = pick_sample(last);
                send_sample(last, 1'b0, none);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                results_taken++;
            if (!long_done && results_taken >= 120)
            begin
                long_done = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else if ($urandom_range(0, 9) < 3)
            begin
                m_axis_tready <= 1'b0;
                hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 80);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        estimate_t got;
        estimate_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.srtt = m_axis_tdata[31:0];
            got.rttvar = m_axis_tdata[63:32];
            got.trend = m_axis_tdata[80:64];
            if (exp_wr == exp_rd)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected transaction: srtt %0d rttvar %0d trend %0d",
                             got.srtt, got.rttvar, got.trend);
            end
            else
            begin
                want = expected_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.srtt !== want.srtt || got.rttvar !== want.rttvar
                    || got.trend !== want.trend || m_axis_tdata[87:81] !== 7'd0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: srtt %0d/%0d rttvar %0d/%0d trend %0d/%0d (exp/got)",
                                 want.srtt, got.srtt, want.rttvar, got.rttvar,
                                 want.trend, got.trend);
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("trend_adaptive_rtt_estimator test failed");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("trend_adaptive_rtt_estimator test passed");
        else
            $display("trend_adaptive_rtt_estimator test failed");
        $finish;
    end

endmodule

// File: trend_adaptive_rtt_estimator.f
rtl/tare_pkg.sv
rtl/tare_divider.sv
rtl/tare_datapath.sv
rtl/tare_controller.sv
rtl/trend_adaptive_rtt_estimator.sv
tb/trend_adaptive_rtt_estimator_test.sv
